// ===== hdl/wnp_pkg.sv =====
package wnp_pkg;

  localparam int X_W       = 13;
  localparam int DIM_REG_W = 14;
  localparam int SEED_W    = 32;
  localparam int CS_W      = 7;
  localparam int CSQ_W     = 2 * CS_W;
  localparam int M_W       = CSQ_W + 1;
  localparam int CXC_W     = X_W + 2;
  localparam int CXCS_W    = CXC_W + CS_W + 1;
  localparam int HASH_W    = 32;
  localparam int OFF_W     = CS_W + 2;
  localparam int DIST_W    = 2 * OFF_W - 1;
  localparam int VAL_W     = 15;
  localparam int SCALE_W   = 2 * VAL_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int NCOL      = 3;
  localparam int NCELL     = 9;

  localparam int MAX_DIM_DEF    = 8192;
  localparam int STEPS_PER_STG  = 4;

  localparam logic [HASH_W-1:0] HASH_MUL_X = 32'd374761393;
  localparam logic [HASH_W-1:0] HASH_MUL_Y = 32'd668265263;
  localparam logic [HASH_W-1:0] HASH_MUL_F = 32'd1274126177;
  localparam int                HASH_SHIFT = 13;
  localparam logic [VAL_W-1:0]  FULL_SCALE = 15'h7FFF;

  localparam logic [DIM_REG_W-1:0] RST_WIDTH  = 14'd1;
  localparam logic [DIM_REG_W-1:0] RST_HEIGHT = 14'd1;
  localparam logic [SEED_W-1:0]    RST_SEED   = 32'd0;
  localparam logic [CS_W-1:0]      RST_CELL   = 7'd25;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_NOISE_SEED,
    REG_CELL_SIZE
  } cfg_reg_t;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [X_W-1:0] y;
  } pix_ctx_t;

  typedef struct packed {
    logic [X_W-1:0]                   x;
    logic [X_W-1:0]                   y;
    logic [NCOL-1:0][CXCS_W-1:0]      cxcs;
    logic [NCOL-1:0][CXCS_W-1:0]      cycs;
    logic [NCELL-1:0]                 cvld;
    logic                             in_img;
  } cell_ctx_t;

  typedef struct packed {
    logic in_img;
    logic far;
  } fin_ctx_t;

endpackage

// ===== hdl/wnp_div.sv =====
module wnp_div
  import wnp_pkg::*;
#(
  parameter int NUM_W  = 13,
  parameter int DEN_W  = 7,
  parameter int LANES  = 1,
  parameter int SIDE_W = 1,
  parameter int SPS    = STEPS_PER_STG
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num [LANES],
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_quo [LANES],
  output logic [DEN_W-1:0]  out_rem [LANES],
  output logic [SIDE_W-1:0] out_side
);

  localparam int NS = (NUM_W + SPS - 1) / SPS;

  logic              vld_r  [NS];
  logic [SIDE_W-1:0] side_r [NS];
  logic [NUM_W-1:0]  num_r  [NS][LANES];
  logic [DEN_W-1:0]  rem_r  [NS][LANES];

  for (genvar k = 0; k < NS; k++) begin : g_stg
    logic              v_src;
    logic [SIDE_W-1:0] s_src;
    logic [NUM_W-1:0]  n_src   [LANES];
    logic [DEN_W-1:0]  r_src   [LANES];
    logic [NUM_W-1:0]  num_nxt [LANES];
    logic [DEN_W-1:0]  rem_nxt [LANES];

    if (k == 0) begin : g_first
      always_comb begin
        v_src = in_valid;
        s_src = in_side;
        for (int l = 0; l < LANES; l++) begin
          n_src[l] = in_num[l];
          r_src[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        v_src = vld_r[k-1];
        s_src = side_r[k-1];
        for (int l = 0; l < LANES; l++) begin
          n_src[l] = num_r[k-1][l];
          r_src[l] = rem_r[k-1][l];
        end
      end
    end

    always_comb begin
      logic [DEN_W:0]   t;
      logic [NUM_W-1:0] n;
      logic [DEN_W-1:0] r;
      for (int l = 0; l < LANES; l++) begin
        n = n_src[l];
        r = r_src[l];
        for (int j = 0; j < SPS; j++) begin
          if (k * SPS + j < NUM_W) begin
            t = {r, n[NUM_W-1]};
            if (t >= {1'b0, in_den}) begin
              t = t - {1'b0, in_den};
              n = {n[NUM_W-2:0], 1'b1};
            end else begin
              n = {n[NUM_W-2:0], 1'b0};
            end
            r = t[DEN_W-1:0];
          end
        end
        num_nxt[l] = n;
        rem_nxt[l] = r;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= s_src;
        for (int l = 0; l < LANES; l++) begin
          num_r[k][l] <= num_nxt[l];
          rem_r[k][l] <= rem_nxt[l];
        end
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_side  = side_r[NS-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_quo[l] = num_r[NS-1][l];
      out_rem[l] = rem_r[NS-1][l];
    end
  end

endmodule

// ===== hdl/worley_noise_pixel.sv =====
// Throughput: one pixel per cycle unless the output stalls; every stage is a register step
// of a single pipeline. The depth is set by the four long-division pipelines, which resolve
// four quotient bits per stage. A stalled output holds the whole pipeline in place.
// Synchronous active-low reset clears all valid bits and loads the register defaults.
module worley_noise_pixel
  import wnp_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [X_W-1:0]       in_pixel_x,
  input  logic [X_W-1:0]       in_pixel_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VAL_W-1:0]     out_noise_value,
  output logic                 out_inside_res,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  logic en;

  logic [SEED_W-1:0]    seed_r;
  logic [CS_W-1:0]      cse_r;
  logic [CSQ_W-1:0]     csq_r;
  logic [M_W-1:0]       m_r;
  logic [DIM_W-1:0]     w_eff_r, h_eff_r;

  always_ff @(posedge clk) begin
    logic [CS_W-1:0] cs_new;
    cs_new = (cfg_wdata[CS_W-1:0] == '0) ? CS_W'(1) : cfg_wdata[CS_W-1:0];
    if (!rst_n) begin
      seed_r  <= RST_SEED;
      cse_r   <= RST_CELL;
      csq_r   <= CSQ_W'(RST_CELL) * CSQ_W'(RST_CELL);
      m_r     <= M_W'(2) * M_W'(RST_CELL) * M_W'(RST_CELL);
      w_eff_r <= DIM_W'(RST_WIDTH);
      h_eff_r <= DIM_W'(RST_HEIGHT);
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  w_eff_r <= (32'(cfg_wdata[DIM_REG_W-1:0]) > MAX_DIM) ?
                                     DIM_W'(MAX_DIM) : DIM_W'(cfg_wdata[DIM_REG_W-1:0]);
        REG_IMAGE_HEIGHT: h_eff_r <= (32'(cfg_wdata[DIM_REG_W-1:0]) > MAX_DIM) ?
                                     DIM_W'(MAX_DIM) : DIM_W'(cfg_wdata[DIM_REG_W-1:0]);
        REG_NOISE_SEED:   seed_r  <= cfg_wdata[SEED_W-1:0];
        REG_CELL_SIZE: begin
          cse_r <= cs_new;
          csq_r <= CSQ_W'(cs_new) * CSQ_W'(cs_new);
          m_r   <= M_W'(2) * M_W'(cs_new) * M_W'(cs_new);
        end
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // Pixel to cell index.
  logic [X_W-1:0] da_num [2];
  logic [X_W-1:0] da_quo [2];
  pix_ctx_t       da_side_in, da_side;
  logic           da_valid;

  assign da_num[0]  = in_pixel_x;
  assign da_num[1]  = in_pixel_y;
  assign da_side_in = '{x: in_pixel_x, y: in_pixel_y};

  wnp_div #(.NUM_W(X_W), .DEN_W(CS_W), .LANES(2), .SIDE_W($bits(pix_ctx_t))) u_div_cell (
    .clk, .rst_n, .en,
    .in_valid (in_valid),
    .in_num   (da_num),
    .in_den   (cse_r),
    .in_side  (da_side_in),
    .out_valid(da_valid),
    .out_quo  (da_quo),
    .out_rem  (),
    .out_side (da_side)
  );

  // Neighbor cell indexes and their pixel origins.
  logic                 b_vld_r, b_inside_r;
  logic [X_W-1:0]       b_x_r, b_y_r;
  logic [CXC_W-1:0]     b_cx_r [NCOL], b_cy_r [NCOL];
  logic [CXCS_W-1:0]    b_cxcs_r [NCOL], b_cycs_r [NCOL];
  logic [CXC_W-1:0]     b_cx_nxt [NCOL], b_cy_nxt [NCOL];

  always_comb begin
    for (int i = 0; i < NCOL; i++) begin
      b_cx_nxt[i] = CXC_W'({2'b00, da_quo[0]}) + CXC_W'(i) - CXC_W'(1);
      b_cy_nxt[i] = CXC_W'({2'b00, da_quo[1]}) + CXC_W'(i) - CXC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= da_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [CXCS_W-1:0] px, py;
    if (en) begin
      b_x_r      <= da_side.x;
      b_y_r      <= da_side.y;
      b_inside_r <= (32'(da_side.x) < 32'(w_eff_r)) && (32'(da_side.y) < 32'(h_eff_r));
      for (int i = 0; i < NCOL; i++) begin
        px = $signed(b_cx_nxt[i]) * $signed({1'b0, cse_r});
        py = $signed(b_cy_nxt[i]) * $signed({1'b0, cse_r});
        b_cx_r[i]   <= b_cx_nxt[i];
        b_cy_r[i]   <= b_cy_nxt[i];
        b_cxcs_r[i] <= px;
        b_cycs_r[i] <= py;
      end
    end
  end

  // Cell validity and the per-axis hash terms.
  logic              c_vld_r, c_inside_r;
  logic [X_W-1:0]    c_x_r, c_y_r;
  logic [CXCS_W-1:0] c_cxcs_r [NCOL], c_cycs_r [NCOL];
  logic [NCOL-1:0]   c_vx_r, c_vy_r;
  logic [HASH_W-1:0] c_tx_r [NCOL], c_ty_r [NCOL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [HASH_W-1:0] sx, sy;
    if (en) begin
      c_x_r      <= b_x_r;
      c_y_r      <= b_y_r;
      c_inside_r <= b_inside_r;
      for (int i = 0; i < NCOL; i++) begin
        sx = {{(HASH_W-CXC_W){b_cx_r[i][CXC_W-1]}}, b_cx_r[i]} + seed_r;
        sy = {{(HASH_W-CXC_W){b_cy_r[i][CXC_W-1]}}, b_cy_r[i]} + seed_r;
        c_tx_r[i]   <= sx * HASH_MUL_X;
        c_ty_r[i]   <= sy * HASH_MUL_Y;
        c_vx_r[i]   <= !b_cx_r[i][CXC_W-1] &&
                       (32'(b_cxcs_r[i][CXCS_W-2:0]) < 32'(w_eff_r));
        c_vy_r[i]   <= !b_cy_r[i][CXC_W-1] &&
                       (32'(b_cycs_r[i][CXCS_W-2:0]) < 32'(h_eff_r));
        c_cxcs_r[i] <= b_cxcs_r[i];
        c_cycs_r[i] <= b_cycs_r[i];
      end
    end
  end

  // Hash sum and xor-shift.
  logic              d_vld_r, d_inside_r;
  logic [X_W-1:0]    d_x_r, d_y_r;
  logic [CXCS_W-1:0] d_cxcs_r [NCOL], d_cycs_r [NCOL];
  logic [NCELL-1:0]  d_cvld_r;
  logic [HASH_W-1:0] d_hs_r [NCELL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [HASH_W-1:0] h0;
    if (en) begin
      d_x_r      <= c_x_r;
      d_y_r      <= c_y_r;
      d_inside_r <= c_inside_r;
      d_cxcs_r   <= c_cxcs_r;
      d_cycs_r   <= c_cycs_r;
      for (int k = 0; k < NCELL; k++) begin
        h0 = c_tx_r[k % NCOL] + c_ty_r[k / NCOL];
        d_hs_r[k]   <= h0 ^ (h0 >> HASH_SHIFT);
        d_cvld_r[k] <= c_vx_r[k % NCOL] && c_vy_r[k / NCOL];
      end
    end
  end

  // Final hash multiply.
  logic              e_vld_r;
  cell_ctx_t         e_ctx_r;
  logic [HASH_W-1:0] e_h_r [NCELL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_ctx_r.x      <= d_x_r;
      e_ctx_r.y      <= d_y_r;
      e_ctx_r.in_img <= d_inside_r;
      e_ctx_r.cvld   <= d_cvld_r;
      for (int i = 0; i < NCOL; i++) begin
        e_ctx_r.cxcs[i] <= d_cxcs_r[i];
        e_ctx_r.cycs[i] <= d_cycs_r[i];
      end
      for (int k = 0; k < NCELL; k++) begin
        e_h_r[k] <= d_hs_r[k] * HASH_MUL_F;
      end
    end
  end

  // The hash modulo cell_size squared splits into both feature offsets.
  logic [CSQ_W-1:0] hm_rem [NCELL];
  cell_ctx_t        hm_side;
  logic             hm_valid;

  wnp_div #(.NUM_W(HASH_W), .DEN_W(CSQ_W), .LANES(NCELL), .SIDE_W($bits(cell_ctx_t)))
  u_div_hash (
    .clk, .rst_n, .en,
    .in_valid (e_vld_r),
    .in_num   (e_h_r),
    .in_den   (csq_r),
    .in_side  (e_ctx_r),
    .out_valid(hm_valid),
    .out_quo  (),
    .out_rem  (hm_rem),
    .out_side (hm_side)
  );

  logic [CSQ_W-1:0] of_quo [NCELL];
  logic [CS_W-1:0]  of_rem [NCELL];
  cell_ctx_t        of_side;
  logic             of_valid;

  wnp_div #(.NUM_W(CSQ_W), .DEN_W(CS_W), .LANES(NCELL), .SIDE_W($bits(cell_ctx_t)))
  u_div_offs (
    .clk, .rst_n, .en,
    .in_valid (hm_valid),
    .in_num   (hm_rem),
    .in_den   (cse_r),
    .in_side  (hm_side),
    .out_valid(of_valid),
    .out_quo  (of_quo),
    .out_rem  (of_rem),
    .out_side (of_side)
  );

  // Offsets from the pixel to each feature point.
  logic             f_vld_r, f_inside_r;
  logic [NCELL-1:0] f_cvld_r;
  logic [OFF_W-1:0] f_ex_r [NCELL], f_ey_r [NCELL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= of_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [CXCS_W+1:0] ex, ey;
    if (en) begin
      f_inside_r <= of_side.in_img;
      f_cvld_r   <= of_side.cvld;
      for (int k = 0; k < NCELL; k++) begin
        ex = $signed({{(CXCS_W+2-X_W){1'b0}}, of_side.x})
           - $signed({{2{of_side.cxcs[k % NCOL][CXCS_W-1]}}, of_side.cxcs[k % NCOL]})
           - $signed({{(CXCS_W+2-CS_W){1'b0}}, of_rem[k]});
        ey = $signed({{(CXCS_W+2-X_W){1'b0}}, of_side.y})
           - $signed({{2{of_side.cycs[k / NCOL][CXCS_W-1]}}, of_side.cycs[k / NCOL]})
           - $signed({{(CXCS_W+2-CS_W){1'b0}}, of_quo[k][CS_W-1:0]});
        f_ex_r[k] <= ex[OFF_W-1:0];
        f_ey_r[k] <= ey[OFF_W-1:0];
      end
    end
  end

  // Squared distances; cells outside the grid read as the largest distance.
  logic              g_vld_r, g_inside_r;
  logic [DIST_W-1:0] g_dist_r [NCELL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [2*OFF_W-1:0] sx, sy;
    if (en) begin
      g_inside_r <= f_inside_r;
      for (int k = 0; k < NCELL; k++) begin
        sx = $signed(f_ex_r[k]) * $signed(f_ex_r[k]);
        sy = $signed(f_ey_r[k]) * $signed(f_ey_r[k]);
        g_dist_r[k] <= f_cvld_r[k] ? (sx[DIST_W-1:0] + sy[DIST_W-1:0]) : '1;
      end
    end
  end

  function automatic logic [DIST_W-1:0] min3(input logic [DIST_W-1:0] a,
                                             input logic [DIST_W-1:0] b,
                                             input logic [DIST_W-1:0] c);
    logic [DIST_W-1:0] m;
    m = (b < a) ? b : a;
    return (c < m) ? c : m;
  endfunction

  logic              h_vld_r, h_inside_r;
  logic [DIST_W-1:0] h_min_r [NCOL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
    end else if (en) begin
      h_vld_r <= g_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_inside_r <= g_inside_r;
      for (int j = 0; j < NCOL; j++) begin
        h_min_r[j] <= min3(g_dist_r[3*j], g_dist_r[3*j+1], g_dist_r[3*j+2]);
      end
    end
  end

  logic              i_vld_r, i_inside_r;
  logic [DIST_W-1:0] i_best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_vld_r <= 1'b0;
    end else if (en) begin
      i_vld_r <= h_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_inside_r <= h_inside_r;
      i_best_r   <= min3(h_min_r[0], h_min_r[1], h_min_r[2]);
    end
  end

  // Scale the distance margin before the final division by M.
  logic               j_vld_r;
  fin_ctx_t           j_ctx_r;
  logic [SCALE_W-1:0] j_num_r [1];
  logic [M_W-1:0]     j_diff;

  assign j_diff = m_r - i_best_r[M_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_vld_r <= 1'b0;
    end else if (en) begin
      j_vld_r <= i_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j_ctx_r.in_img <= i_inside_r;
      j_ctx_r.far    <= 32'(i_best_r) >= 32'(m_r);
      j_num_r[0]     <= SCALE_W'(FULL_SCALE) * SCALE_W'(j_diff);
    end
  end

  logic [SCALE_W-1:0] fd_quo [1];
  logic [M_W-1:0]     fd_rem [1];
  fin_ctx_t           fd_side;
  logic               fd_valid;

  wnp_div #(.NUM_W(SCALE_W), .DEN_W(M_W), .LANES(1), .SIDE_W($bits(fin_ctx_t))) u_div_scale (
    .clk, .rst_n, .en,
    .in_valid (j_vld_r),
    .in_num   (j_num_r),
    .in_den   (m_r),
    .in_side  (j_ctx_r),
    .out_valid(fd_valid),
    .out_quo  (fd_quo),
    .out_rem  (fd_rem),
    .out_side (fd_side)
  );

  logic [VAL_W-1:0] out_value_r;
  logic             out_inside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_inside_r <= fd_side.in_img;
      out_value_r  <= (fd_side.in_img && !fd_side.far && (fd_rem[0] <= m_r)) ?
                      fd_quo[0][VAL_W-1:0] : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_value_r;
  assign out_inside_res  = out_inside_r;

endmodule

// ===== hdl/wnp_checker.sv =====
module wnp_checker
  import wnp_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [X_W-1:0]       in_pixel_x,
  input logic [X_W-1:0]       in_pixel_y,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [VAL_W-1:0]     out_noise_value,
  input logic                 out_inside_res,
  input logic                 cfg_wr_en,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_DAT_W-1:0] cfg_wdata
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_noise_value)
                               && $stable(out_inside_res))
    else $error("stalled result beat changed");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_inside_res |-> out_noise_value == '0)
    else $error("pixel outside the image gave a nonzero value");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result beat");

endmodule

bind worley_noise_pixel wnp_checker u_wnp_checker (.*);

// ===== bench/worley_noise_pixel_test.sv =====
`timescale 1ns / 100ps

class noise_scoreboard;
  logic [14:0] want_value[$];
  logic        want_inside[$];
  int          errors;
  logic [13:0] width_r;
  logic [13:0] height_r;
  logic [31:0] seed_r;
  logic [6:0]  cell_r;

  function new();
    errors = 0;
    width_r = 14'd1;
    height_r = 14'd1;
    seed_r = 32'd0;
    cell_r = 7'd25;
  endfunction

  function void write_reg(wnp_pkg::cfg_reg_t idx, logic [31:0] value);
    case (idx)
      wnp_pkg::REG_IMAGE_WIDTH: width_r = value[13:0];
      wnp_pkg::REG_IMAGE_HEIGHT: height_r = value[13:0];
      wnp_pkg::REG_NOISE_SEED: seed_r = value;
      wnp_pkg::REG_CELL_SIZE: cell_r = value[6:0];
      default: ;
    endcase
  endfunction

  function logic [31:0] place_hash(longint cx, longint cy);
    logic [31:0] h;
    h = (32'(cx) + seed_r) * wnp_pkg::HASH_MUL_X + (32'(cy) + seed_r) * wnp_pkg::HASH_MUL_Y;
    h = (h ^ (h >> wnp_pkg::HASH_SHIFT)) * wnp_pkg::HASH_MUL_F;
    return h;
  endfunction

  function void note_pixel(logic [12:0] px, logic [12:0] py);
    longint w, hg, cs, ncx, ncy, best, m, cx, cy, fx, fy, sq_dist, x, y;
    logic [31:0] h;
    x = px;
    y = py;
    w = (width_r > 8192) ? 8192 : width_r;
    hg = (height_r > 8192) ? 8192 : height_r;
    cs = (cell_r == 0) ? 1 : cell_r;
    if (x >= w || y >= hg) begin
      want_value.push_back(15'd0);
      want_inside.push_back(1'b0);
      return;
    end
    ncx = (w + cs - 1) / cs;
    ncy = (hg + cs - 1) / cs;
    best = -1;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        cx = x / cs + dx;
        cy = y / cs + dy;
        if (cx < 0 || cx >= ncx || cy < 0 || cy >= ncy) continue;
        h = place_hash(cx, cy);
        fx = cx * cs + longint'(h % 32'(cs));
        fy = cy * cs + longint'((h / 32'(cs)) % 32'(cs));
        sq_dist = (x - fx) * (x - fx) + (y - fy) * (y - fy);
        if (best < 0 || sq_dist < best) best = sq_dist;
      end
    end
    if (best < 0) best = 0;
    m = 2 * cs * cs;
    if (best >= m) want_value.push_back(15'd0);
    else want_value.push_back(15'((32767 * (m - best)) / m));
    want_inside.push_back(1'b1);
  endfunction

  function void check_result(logic [14:0] value, logic in_img);
    logic [14:0] ev;
    logic ei;
    if (want_value.size() == 0) begin
      $display("%0t: unexpected beat value=%0d inside=%0d", $time, value, in_img);
      errors++;
      return;
    end
    ev = want_value.pop_front();
    ei = want_inside.pop_front();
    if (ev !== value) begin
      $display("%0t: noise_value expected %0d actual %0d", $time, ev, value);
      errors++;
    end
    if (ei !== in_img) begin
      $display("%0t: inside_res expected %0d actual %0d", $time, ei, in_img);
      errors++;
    end
  endfunction
endclass

module worley_noise_pixel_test;
  import wnp_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [12:0] in_pixel_x = '0;
  logic [12:0] in_pixel_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [14:0] out_noise_value;
  logic out_inside_res;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic out_run = 1'b0;
  int idle_cycles = 0;
  noise_scoreboard board = new();

  worley_noise_pixel dut (.*);

  always #6 clk = ~clk;

  function int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_result(out_noise_value, out_inside_res);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int g;
    forever begin
      @(posedge clk);
      if (out_run) begin
        if (out_stall) begin
          if (g > 0) g--;
          else out_stall <= 1'b0;
        end else begin
          g = gap_len();
          if (g > 0) begin
            g--;
            out_stall <= 1'b1;
          end
        end
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    board.write_reg(idx, value);
  endtask

  task automatic setup(int w, int h, logic [31:0] seed, int cs);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_NOISE_SEED, seed);
    write_reg(REG_CELL_SIZE, cs);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_pixel(logic [12:0] px, logic [12:0] py, bit pause);
    int g;
    g = pause ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    do @(posedge clk); while (in_stall);
    board.note_pixel(px, py);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.want_value.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_phase(int count, int w, int h);
    logic [12:0] px, py;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        px = 13'($urandom);
        py = 13'($urandom);
      end else begin
        px = 13'($urandom_range(0, w));
        py = 13'($urandom_range(0, h));
      end
      send_pixel(px, py, i % 200 < 150);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_pixel(0, 0, 0);
    send_pixel(1, 0, 0);
    drain();
    setup(100, 80, 32'h1234_5678, 25);
    send_pixel(0, 0, 0);
    send_pixel(99, 79, 0);
    send_pixel(100, 0, 0);
    send_pixel(0, 80, 0);
    send_pixel(13'h1FFF, 13'h1FFF, 0);
    send_pixel(50, 40, 0);
    drain();
    setup(16383, 16383, 32'hFFFF_FFFF, 0);
    send_pixel(0, 0, 0);
    send_pixel(8191, 8191, 0);
    send_pixel(4096, 1, 0);
    drain();
    setup(8192, 8192, 0, 100);
    send_pixel(8191, 8191, 0);
    send_pixel(8191, 0, 0);
    send_pixel(0, 8191, 0);
    send_pixel(5555, 2222, 0);
    drain();
    setup(1, 8192, 32'hA5A5_5A5A, 1);
    send_pixel(0, 8191, 0);
    send_pixel(1, 5, 0);
    drain();
    out_run <= 1'b1;
    setup(300, 200, $urandom, 7);
    random_phase(400, 320, 210);
    drain();
    setup(8192, 8192, $urandom, 100);
    random_phase(400, 8191, 8191);
    drain();
    setup($urandom_range(1, 16383), $urandom_range(1, 16383), $urandom,
          $urandom_range(0, 127));
    random_phase(400, 8191, 8191);
    drain();
    setup($urandom_range(1, 600), $urandom_range(1, 600), $urandom, $urandom_range(1, 20));
    random_phase(400, 620, 620);
    drain();
    out_run <= 1'b0;
    repeat (4) @(posedge clk);
    if (board.errors == 0 && board.want_value.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
